[sv/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// rrs_pkg
// shared types and constants of the round-robin slice scheduler
// ----------------------------------------------------------------------------
package rrs_pkg;

   localparam int unsigned TIME_W  = 12;   // arrival, burst, remaining, quantum
   localparam int unsigned CLOCK_W = 16;   // scheduler clock
   localparam int unsigned ID_W    = 5;    // process id as reported
   localparam int unsigned SPAN_W  = 17;   // signed turnaround and waiting
   localparam int unsigned CMD_W   = 2;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [CLOCK_W-1:0] clock_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [SPAN_W-1:0]  span_type;

   localparam cmd_type CMD_CLEAR    = 2'd0;
   localparam cmd_type CMD_LOAD     = 2'd1;
   localparam cmd_type CMD_SCHEDULE = 2'd2;

   // one process table entry
   typedef struct packed {
      time_type arrival;
      time_type burst;
      time_type remaining;
      id_type   id;
   } entry_type;

endpackage

[sv/rrs_req_if.sv]
// ----------------------------------------------------------------------------
// rrs_req_if
// command channel of the scheduler, valid/ready handshake
// ----------------------------------------------------------------------------
interface rrs_req_if;
   logic               valid;
   logic               ready;
   rrs_pkg::cmd_type   command;
   rrs_pkg::time_type  arrival_time;
   rrs_pkg::time_type  burst_time;

   modport source (output valid, command, arrival_time, burst_time, input ready);
   modport sink   (input valid, command, arrival_time, burst_time, output ready);
endinterface

[sv/rrs_rsp_if.sv]
// ----------------------------------------------------------------------------
// rrs_rsp_if
// slice result channel of the scheduler, valid/ready handshake
// ----------------------------------------------------------------------------
interface rrs_rsp_if;
   logic                valid;
   logic                ready;
   rrs_pkg::id_type     process_id;
   rrs_pkg::clock_type  slice_start;
   rrs_pkg::time_type   slice_length;
   logic                finished;
   logic signed [16:0]  turnaround;
   logic signed [16:0]  waiting;
   logic                all_done;

   modport source (output valid, process_id, slice_start, slice_length, finished,
                   turnaround, waiting, all_done, input ready);
   modport sink   (input valid, process_id, slice_start, slice_length, finished,
                   turnaround, waiting, all_done, output ready);
endinterface

[sv/round_robin_slice_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// round-robin process table with one slice issued per schedule transaction
// ----------------------------------------------------------------------------
// The block holds up to MAX_PROCS processes ordered by arrival (equal arrivals
// keep load order) in a single-port-write, registered-read table memory; done
// marks live in flip-flops and clear at once. It takes one transaction at a
// time. A clear takes effect on the handshake itself. A load moves each later
// entry up one slot for the ordered insertion (one memory read and one write each),
// then writes the new entry into the freed slot. A schedule scans the done marks
// one entry per cycle from the cursor, then reads the entry and runs the slice
// arithmetic through one shared 17-bit add/subtract unit (remaining, clock,
// turnaround, waiting); turnaround and waiting are only reckoned when the slice
// finishes the process. An empty table answers with all_done without a scan, a
// fully finished one after the scan. The result sits in an output register; the
// next transaction is taken while it waits, and only the final step of a later
// schedule stalls on a full output.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler #(
   parameter int unsigned MAX_PROCS = 16
) (
   input  logic                clock,
   input  logic                reset,
   rrs_req_if.sink             req_chan,
   rrs_rsp_if.source           rsp_chan,
   input  logic                csr_write_en,
   input  rrs_pkg::time_type   csr_write_data
);

   localparam int unsigned IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_READ,   // issue read of the entry below the insert slot, or write at slot 0
      ST_LD_CHECK,  // move it up or drop the new entry in
      ST_SC_SCAN,   // walk done marks from the cursor
      ST_SC_READ,   // entry data back, pick slice length
      ST_SC_REM,    // remaining minus run
      ST_SC_CLK,    // clock plus run
      ST_SC_TURN,   // end minus arrival
      ST_SC_WAIT,   // turnaround minus burst
      ST_SC_OUT     // hand the result to the output register
   } state_type;

   // control state
   state_type              state_ff,  state_in;
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic [IDX_W-1:0]       cursor_ff, cursor_in;
   rrs_pkg::clock_type     clock_ff,  clock_in;
   logic [MAX_PROCS-1:0]   done_ff,   done_in;
   rrs_pkg::time_type      tq_ff,     tq_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [IDX_W-1:0]       pos_ff,    pos_in;     // insert slot, also scan index
   logic [IDX_W-1:0]       steps_ff,  steps_in;   // entries scanned so far
   rrs_pkg::time_type      arr_ff,    arr_in;
   rrs_pkg::time_type      bur_ff,    bur_in;
   rrs_pkg::entry_type     ent_ff,    ent_in;
   rrs_pkg::time_type      run_ff,    run_in;
   rrs_pkg::clock_type     start_ff,  start_in;
   rrs_pkg::span_type      turn_ff,   turn_in;
   rrs_pkg::span_type      wait_ff,   wait_in;
   logic                   found_ff,  found_in;
   logic                   fin_ff,    fin_in;

   // result registers
   rrs_pkg::id_type        o_id_ff,     o_id_in;
   rrs_pkg::clock_type     o_start_ff,  o_start_in;
   rrs_pkg::time_type      o_len_ff,    o_len_in;
   logic                   o_fin_ff,    o_fin_in;
   rrs_pkg::span_type      o_turn_ff,   o_turn_in;
   rrs_pkg::span_type      o_wait_ff,   o_wait_in;
   logic                   o_alldone_ff, o_alldone_in;

   // table memory
   rrs_pkg::entry_type     table_mem [MAX_PROCS];
   rrs_pkg::entry_type     mem_rdata_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [IDX_W-1:0]       mem_raddr;
   rrs_pkg::entry_type     mem_wdata;

   // shared add/subtract unit
   rrs_pkg::span_type      alu_a, alu_b, alu_res;
   logic                   alu_sub;

   logic                   req_fire;
   rrs_pkg::time_type      quantum;
   rrs_pkg::id_type        new_id;
   logic [IDX_W-1:0]       idx_next;
   logic                   idx_wraps;
   rrs_pkg::entry_type     new_entry;

   assign req_fire  = req_chan.valid && req_chan.ready;
   // a zero quantum acts as one
   assign quantum   = (tq_ff == '0) ? rrs_pkg::TIME_W'(1) : tq_ff;
   // ids are reported modulo 32
   assign new_id    = rrs_pkg::ID_W'(count_ff) + rrs_pkg::ID_W'(1);
   // cyclic successor of the scan index within the loaded entries
   assign idx_wraps = (CNT_W'(pos_ff) + CNT_W'(1)) == count_ff;
   assign idx_next  = idx_wraps ? '0 : pos_ff + IDX_W'(1);
   assign new_entry = '{arrival: arr_ff, burst: bur_ff, remaining: bur_ff, id: new_id};

   // operand select for the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_SC_REM: begin
            alu_a   = rrs_pkg::SPAN_W'(ent_ff.remaining);
            alu_b   = rrs_pkg::SPAN_W'(run_ff);
            alu_sub = 1'b1;
         end
         ST_SC_CLK: begin
            alu_a   = rrs_pkg::SPAN_W'(clock_ff);
            alu_b   = rrs_pkg::SPAN_W'(run_ff);
         end
         ST_SC_TURN: begin
            alu_a   = rrs_pkg::SPAN_W'(clock_ff);
            alu_b   = rrs_pkg::SPAN_W'(ent_ff.arrival);
            alu_sub = 1'b1;
         end
         ST_SC_WAIT: begin
            alu_a   = turn_ff;
            alu_b   = rrs_pkg::SPAN_W'(ent_ff.burst);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      clock_in     = clock_ff;
      done_in      = done_ff;
      tq_in        = csr_write_en ? csr_write_data : tq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      arr_in       = arr_ff;
      bur_in       = bur_ff;
      ent_in       = ent_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      turn_in      = turn_ff;
      wait_in      = wait_ff;
      found_in     = found_ff;
      fin_in       = fin_ff;
      o_id_in      = o_id_ff;
      o_start_in   = o_start_ff;
      o_len_in     = o_len_ff;
      o_fin_in     = o_fin_ff;
      o_turn_in    = o_turn_ff;
      o_wait_in    = o_wait_ff;
      o_alldone_in = o_alldone_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = new_entry;
      mem_raddr    = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.command)
                  rrs_pkg::CMD_CLEAR: begin
                     count_in  = '0;
                     cursor_in = '0;
                     clock_in  = '0;
                     done_in   = '0;
                  end
                  rrs_pkg::CMD_LOAD: begin
                     arr_in = req_chan.arrival_time;
                     bur_in = req_chan.burst_time;
                     pos_in = IDX_W'(count_ff);
                     // a full table ignores the load
                     if (count_ff != CNT_W'(MAX_PROCS)) begin
                        state_in = ST_LD_READ;
                     end
                  end
                  rrs_pkg::CMD_SCHEDULE: begin
                     pos_in   = cursor_ff;
                     steps_in = '0;
                     found_in = 1'b0;
                     fin_in   = 1'b0;
                     state_in = (count_ff == '0) ? ST_SC_OUT : ST_SC_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_LD_READ: begin
            if (pos_ff == '0) begin
               mem_we        = 1'b1;
               done_in[pos_ff] = 1'b0;
               count_in      = count_ff + CNT_W'(1);
               state_in      = ST_IDLE;
            end else begin
               mem_raddr = pos_ff - IDX_W'(1);
               state_in  = ST_LD_CHECK;
            end
         end

         ST_LD_CHECK: begin
            mem_we = 1'b1;
            if (mem_rdata_ff.arrival > arr_ff) begin
               // later arrival moves up one slot with its done mark
               mem_wdata       = mem_rdata_ff;
               done_in[pos_ff] = done_ff[pos_ff - IDX_W'(1)];
               pos_in          = pos_ff - IDX_W'(1);
               state_in        = ST_LD_READ;
            end else begin
               done_in[pos_ff] = 1'b0;
               count_in        = count_ff + CNT_W'(1);
               state_in        = ST_IDLE;
            end
         end

         ST_SC_SCAN: begin
            if (!done_ff[pos_ff]) begin
               found_in = 1'b1;
               state_in = ST_SC_READ;
            end else if ((CNT_W'(steps_ff) + CNT_W'(1)) == count_ff) begin
               state_in = ST_SC_OUT;
            end else begin
               steps_in = steps_ff + IDX_W'(1);
               pos_in   = idx_next;
            end
         end

         ST_SC_READ: begin
            ent_in   = mem_rdata_ff;
            run_in   = (mem_rdata_ff.remaining > quantum) ? quantum : mem_rdata_ff.remaining;
            state_in = ST_SC_REM;
         end

         ST_SC_REM: begin
            ent_in.remaining = alu_res[rrs_pkg::TIME_W-1:0];
            mem_we           = 1'b1;
            mem_wdata        = ent_ff;
            mem_wdata.remaining = alu_res[rrs_pkg::TIME_W-1:0];
            state_in         = ST_SC_CLK;
         end

         ST_SC_CLK: begin
            start_in = clock_ff;
            clock_in = alu_res[rrs_pkg::CLOCK_W-1:0];
            turn_in  = '0;
            wait_in  = '0;
            if (ent_ff.remaining == '0) begin
               fin_in          = 1'b1;
               done_in[pos_ff] = 1'b1;
               state_in        = ST_SC_TURN;
            end else begin
               state_in        = ST_SC_OUT;
            end
         end

         ST_SC_TURN: begin
            turn_in  = alu_res;
            state_in = ST_SC_WAIT;
         end

         ST_SC_WAIT: begin
            wait_in  = alu_res;
            state_in = ST_SC_OUT;
         end

         ST_SC_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  o_id_in      = ent_ff.id;
                  o_start_in   = start_ff;
                  o_len_in     = run_ff;
                  o_fin_in     = fin_ff;
                  o_turn_in    = turn_ff;
                  o_wait_in    = wait_ff;
                  o_alldone_in = 1'b0;
                  cursor_in    = idx_next;
               end else begin
                  o_id_in      = '0;
                  o_start_in   = '0;
                  o_len_in     = '0;
                  o_fin_in     = 1'b0;
                  o_turn_in    = '0;
                  o_wait_in    = '0;
                  o_alldone_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         clock_ff     <= '0;
         done_ff      <= '0;
         tq_ff        <= rrs_pkg::TIME_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         clock_ff     <= clock_in;
         done_ff      <= done_in;
         tq_ff        <= tq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      steps_ff     <= steps_in;
      arr_ff       <= arr_in;
      bur_ff       <= bur_in;
      ent_ff       <= ent_in;
      run_ff       <= run_in;
      start_ff     <= start_in;
      turn_ff      <= turn_in;
      wait_ff      <= wait_in;
      found_ff     <= found_in;
      fin_ff       <= fin_in;
      o_id_ff      <= o_id_in;
      o_start_ff   <= o_start_in;
      o_len_ff     <= o_len_in;
      o_fin_ff     <= o_fin_in;
      o_turn_ff    <= o_turn_in;
      o_wait_ff    <= o_wait_in;
      o_alldone_ff <= o_alldone_in;
   end

   // process table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= table_mem[mem_raddr];
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.process_id   = o_id_ff;
   assign rsp_chan.slice_start  = o_start_ff;
   assign rsp_chan.slice_length = o_len_ff;
   assign rsp_chan.finished     = o_fin_ff;
   assign rsp_chan.turnaround   = o_turn_ff;
   assign rsp_chan.waiting      = o_wait_ff;
   assign rsp_chan.all_done     = o_alldone_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives clear, load and schedule transactions into the round-robin slice
// scheduler and checks every slice result against an in-bench model of
// the process table, the cursor and the scheduler clock. The time quantum
// changes between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TABLE_DEPTH   = 16;
   localparam int SETTLE_CYCLES = 40;    // long enough for the longest load
   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
   localparam int PHASE_ITEMS   = 60;
   localparam int IDLE_PERCENT  = 28;

   // command 3 is not decoded by the block
   localparam rrs_pkg::cmd_type CMD_UNUSED = 2'd3;

   typedef struct packed {
      rrs_pkg::cmd_type  command;
      rrs_pkg::time_type arrival;
      rrs_pkg::time_type burst;
   } command_item_type;

   typedef struct {
      rrs_pkg::id_type    process_id;
      rrs_pkg::clock_type slice_start;
      rrs_pkg::time_type  slice_length;
      logic               finished;
      logic signed [16:0] turnaround;
      logic signed [16:0] waiting;
      logic               all_done;
   } slice_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   rrs_pkg::time_type csr_write_data = '0;

   rrs_req_if req_chan ();
   rrs_rsp_if rsp_chan ();

   round_robin_slice_scheduler #(
      .MAX_PROCS (TABLE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus waiting for the driver, and slices waiting for the monitor
   command_item_type pending_commands[$];
   slice_result_type expected_slices[$];

   int  mismatch_count = 0;
   int  phase_items    = 0;
   bit  steady_flow    = 1'b0;   // no idling on either side while set

   // ------------------------------------------------------------------------
   // scheduler model: process table kept sorted by arrival
   // ------------------------------------------------------------------------
   rrs_pkg::time_type  tab_arrival [TABLE_DEPTH];
   rrs_pkg::time_type  tab_burst   [TABLE_DEPTH];
   rrs_pkg::time_type  tab_left    [TABLE_DEPTH];
   rrs_pkg::id_type    tab_id      [TABLE_DEPTH];
   bit                 tab_done    [TABLE_DEPTH];
   int                 tab_count      = 0;
   int                 scan_pos       = 0;
   rrs_pkg::clock_type sched_time     = '0;
   rrs_pkg::time_type  quantum_setting = 12'd1;

   // update the table for one accepted transaction and queue its slice, if any
   function automatic void apply_command(rrs_pkg::cmd_type command,
                                         rrs_pkg::time_type arrival,
                                         rrs_pkg::time_type burst);
      int                pos;
      int                pick;
      int                end_t;
      int                turn;
      int                wait_span;
      rrs_pkg::time_type q_eff;
      rrs_pkg::time_type run;
      slice_result_type  res;
      res = '{default: '0};
      case (command)
         rrs_pkg::CMD_CLEAR: begin
            foreach (tab_done[k]) tab_done[k] = 1'b0;
            tab_count  = 0;
            scan_pos   = 0;
            sched_time = '0;
         end
         rrs_pkg::CMD_LOAD: begin
            // a full table drops the load
            if (tab_count < TABLE_DEPTH) begin
               pos = tab_count;
               // equal arrivals stay behind earlier loads
               while (pos > 0 && tab_arrival[pos-1] > arrival) begin
                  tab_arrival[pos] = tab_arrival[pos-1];
                  tab_burst[pos]   = tab_burst[pos-1];
                  tab_left[pos]    = tab_left[pos-1];
                  tab_id[pos]      = tab_id[pos-1];
                  tab_done[pos]    = tab_done[pos-1];
                  pos--;
               end
               tab_arrival[pos] = arrival;
               tab_burst[pos]   = burst;
               tab_left[pos]    = burst;
               tab_id[pos]      = rrs_pkg::id_type'(tab_count + 1);
               tab_done[pos]    = 1'b0;
               tab_count++;
            end
         end
         rrs_pkg::CMD_SCHEDULE: begin
            pick = -1;
            for (int k = 0; k < tab_count; k++) begin
               if (pick < 0 && !tab_done[(scan_pos + k) % tab_count])
                  pick = (scan_pos + k) % tab_count;
            end
            if (pick < 0) begin
               // empty table or everything finished
               res.all_done = 1'b1;
            end else begin
               q_eff = (quantum_setting == '0) ? rrs_pkg::time_type'(1) : quantum_setting;
               run   = (tab_left[pick] > q_eff) ? q_eff : tab_left[pick];
               res.process_id   = tab_id[pick];
               res.slice_start  = sched_time;
               res.slice_length = run;
               tab_left[pick]   = tab_left[pick] - run;
               sched_time       = sched_time + rrs_pkg::clock_type'(run);
               if (tab_left[pick] == '0) begin
                  tab_done[pick] = 1'b1;
                  // clock never idles, so both spans may go negative
                  end_t     = int'(sched_time);
                  turn      = end_t - int'(tab_arrival[pick]);
                  wait_span = turn - int'(tab_burst[pick]);
                  res.finished   = 1'b1;
                  res.turnaround = turn[16:0];
                  res.waiting    = wait_span[16:0];
               end
               scan_pos = (pick + 1) % tab_count;
            end
            expected_slices.push_back(res);
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // driver: one transaction per handshake, random idle cycles
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_commands
      command_item_type item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // the transaction on the bus is taken at this edge
         if (req_chan.valid && req_chan.ready)
            apply_command(req_chan.command, req_chan.arrival_time, req_chan.burst_time);
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_commands.size() != 0 &&
                (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               item = pending_commands.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.command      <= item.command;
               req_chan.arrival_time <= item.arrival;
               req_chan.burst_time   <= item.burst;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: compare each slice result with the oldest prediction
   // ------------------------------------------------------------------------
   function automatic void check_field(string field_name, longint expected_v,
                                       longint actual_v);
      if (expected_v != actual_v) begin
         $error("%s mismatch: expected %0d, got %0d", field_name, expected_v, actual_v);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch_slices
      slice_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_slices.size() == 0) begin
               $error("slice result arrived with no schedule transaction outstanding");
               mismatch_count++;
            end else begin
               want = expected_slices.pop_front();
               check_field("process_id",   longint'(want.process_id),
                           longint'(rsp_chan.process_id));
               check_field("slice_start",  longint'(want.slice_start),
                           longint'(rsp_chan.slice_start));
               check_field("slice_length", longint'(want.slice_length),
                           longint'(rsp_chan.slice_length));
               check_field("finished",     longint'(want.finished),
                           longint'(rsp_chan.finished));
               check_field("turnaround",   longint'(want.turnaround),
                           longint'(rsp_chan.turnaround));
               check_field("waiting",      longint'(want.waiting),
                           longint'(rsp_chan.waiting));
               check_field("all_done",     longint'(want.all_done),
                           longint'(rsp_chan.all_done));
            end
         end
         rsp_chan.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any transaction on either channel
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic queue_command(rrs_pkg::cmd_type command, rrs_pkg::time_type arrival,
                                rrs_pkg::time_type burst);
      command_item_type item;
      item.command = command;
      item.arrival = arrival;
      item.burst   = burst;
      pending_commands.push_back(item);
      phase_items++;
   endtask

   function automatic int slices_needed(int burst, int q_eff);
      return (burst == 0) ? 1 : (burst + q_eff - 1) / q_eff;
   endfunction

   // one load with random content; tracks table fill and slices still owed
   task automatic add_random_load(bit narrow, int burst_cap, int q_eff,
                                  inout int fill, inout int slices);
      rrs_pkg::time_type arrival;
      rrs_pkg::time_type burst;
      arrival = narrow ? rrs_pkg::time_type'($urandom_range(0, 15))
                       : rrs_pkg::time_type'($urandom_range(0, 4095));
      burst   = ($urandom_range(0, 9) == 0) ? '0
                : rrs_pkg::time_type'($urandom_range(0, burst_cap));
      queue_command(rrs_pkg::CMD_LOAD, arrival, burst);
      if (fill < TABLE_DEPTH) begin
         fill++;
         slices += slices_needed(int'(burst), q_eff);
      end
   endtask

   // clear, fill the table, then schedule until it drains; a little noise
   task automatic queue_schedule_run(int unsigned quantum);
      int q_eff;
      int burst_cap;
      int fill;
      int slices;
      int before_load;
      int sched_left;
      int roll;
      bit narrow;
      q_eff     = (quantum == 0) ? 1 : int'(quantum);
      burst_cap = (q_eff * 3 > 4095) ? 4095 : q_eff * 3;
      narrow    = bit'($urandom_range(0, 1));
      fill      = 0;
      slices    = 0;
      queue_command(rrs_pkg::CMD_CLEAR, rrs_pkg::time_type'($urandom),
                    rrs_pkg::time_type'($urandom));
      // now and then overfill so that loads get dropped
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6))
         add_random_load(narrow, burst_cap, q_eff, fill, slices);
      sched_left = slices + $urandom_range(1, 2);
      if ($urandom_range(0, 19) == 0)
         sched_left = $urandom_range(0, sched_left);
      while (sched_left > 0) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // load while scheduling is under way
            before_load = slices;
            add_random_load(narrow, burst_cap, q_eff, fill, slices);
            sched_left += slices - before_load;
         end else if (roll < 12) begin
            queue_command(CMD_UNUSED, rrs_pkg::time_type'($urandom),
                          rrs_pkg::time_type'($urandom));
         end else if (roll < 14) begin
            queue_command(rrs_pkg::CMD_CLEAR, rrs_pkg::time_type'($urandom),
                          rrs_pkg::time_type'($urandom));
            fill = 0;
            if (sched_left > 2) sched_left = 2;
         end else begin
            queue_command(rrs_pkg::CMD_SCHEDULE, rrs_pkg::time_type'($urandom),
                          rrs_pkg::time_type'($urandom));
            sched_left--;
         end
      end
   endtask

   // wait until every transaction is taken and every slice has come back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_commands.size() != 0 || req_chan.valid ||
             expected_slices.size() != 0);
      // a trailing load may still be shifting entries
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quantum(rrs_pkg::time_type quantum);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= quantum;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      quantum_setting = quantum;
   endtask

   int unsigned quantum_plan[8];

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.command      = rrs_pkg::CMD_CLEAR;
      req_chan.arrival_time = '0;
      req_chan.burst_time   = '0;
      rsp_chan.ready        = 1'b0;

      // directed part runs with the quantum at its reset value of one
      queue_command(rrs_pkg::CMD_SCHEDULE, '0, '0);        // empty table after reset
      queue_command(CMD_UNUSED, 12'hFFF, 12'hFFF);         // undecoded command
      queue_command(rrs_pkg::CMD_LOAD, 12'd4095, 12'd2);
      queue_command(rrs_pkg::CMD_LOAD, 12'd0, 12'd0);      // zero burst, goes to the front
      queue_command(rrs_pkg::CMD_LOAD, 12'd4095, 12'd1);   // equal arrival keeps load order
      queue_command(rrs_pkg::CMD_LOAD, 12'd7, 12'd3);
      // late arrivals give negative spans
      repeat (6) queue_command(rrs_pkg::CMD_SCHEDULE, '0, '0);
      queue_command(rrs_pkg::CMD_LOAD, 12'd2048, 12'd2);   // insert while scheduling
      repeat (6) queue_command(rrs_pkg::CMD_SCHEDULE, 12'hFFF, 12'hFFF);
      queue_command(rrs_pkg::CMD_SCHEDULE, '0, '0);        // everything finished
      queue_command(rrs_pkg::CMD_CLEAR, 12'hFFF, 12'hFFF);
      queue_command(rrs_pkg::CMD_SCHEDULE, '0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      quantum_plan = '{4095, 0, 1, 2, 0, 0, 4095, 1};
      quantum_plan[4] = $urandom_range(1, 4095);
      quantum_plan[5] = $urandom_range(3, 16);

      foreach (quantum_plan[p]) begin
         wait_until_drained();
         write_quantum(rrs_pkg::time_type'(quantum_plan[p]));
         // one phase runs with both sides always ready
         steady_flow = (p == 2);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS)
            queue_schedule_run(quantum_plan[p]);
      end

      wait_until_drained();
      if (mismatch_count == 0 && expected_slices.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
